### hw/rtl/sea_pkg.sv
// Shared widths, types and register indexes for the strided element address generator.
package sea_pkg;

  localparam int ORD_W = 48;
  localparam int EXT_W = 16;
  localparam int ADDR_W = 32;
  localparam int NUM_DIMS = 3;
  localparam int DIM_W = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  typedef logic [NUM_DIMS-1:0][EXT_W-1:0] crd_t;
  typedef logic [NUM_DIMS-1:0][ADDR_W-1:0] prod_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIMS    = 3'd0,
    REG_EXT0    = 3'd1,
    REG_EXT1    = 3'd2,
    REG_EXT2    = 3'd3,
    REG_STRIDE0 = 3'd4,
    REG_STRIDE1 = 3'd5,
    REG_STRIDE2 = 3'd6,
    REG_BASE    = 3'd7
  } cfg_reg_t;

endpackage

### hw/rtl/sea_div.sv
// Pipelined restoring divider, one quotient bit per stage, with coordinate sideband.
module sea_div
  import sea_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [ORD_W-1:0] in_dvd,
  input  logic [EXT_W-1:0] divisor,
  input  crd_t             in_crd,
  output logic             out_valid,
  output logic [ORD_W-1:0] out_quo,
  output logic [EXT_W-1:0] out_rem,
  output crd_t             out_crd
);

  logic             vld [0:ORD_W];
  logic [EXT_W-1:0] rem [0:ORD_W];
  logic [ORD_W-1:0] dvd [0:ORD_W];
  crd_t             crd [0:ORD_W];

  assign vld[0] = in_valid;
  assign rem[0] = '0;
  assign dvd[0] = in_dvd;
  assign crd[0] = in_crd;

  for (genvar j = 0; j < ORD_W; j++) begin : g_stage
    logic [EXT_W:0] trial;
    logic [EXT_W:0] diff;
    logic           ge;

    always_comb begin
      trial = {rem[j], dvd[j][ORD_W-1]};
      diff  = trial - {1'b0, divisor};
      ge    = trial >= {1'b0, divisor};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else if (en) begin
        vld[j+1] <= vld[j];
      end
      if (en) begin
        rem[j+1] <= ge ? diff[EXT_W-1:0] : trial[EXT_W-1:0];
        dvd[j+1] <= {dvd[j][ORD_W-2:0], ge};
        crd[j+1] <= crd[j];
      end
    end
  end

  assign out_valid = vld[ORD_W];
  assign out_quo   = dvd[ORD_W];
  assign out_rem   = rem[ORD_W];
  assign out_crd   = crd[ORD_W];

endmodule

### hw/rtl/sea_mac.sv
// Coordinate times stride products and the final address sum, with the output register.
module sea_mac
  import sea_pkg::*;
(
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_valid,
  input  crd_t                           in_crd,
  input  logic [NUM_DIMS-1:0][ADDR_W-1:0] stride,
  input  logic [ADDR_W-1:0]              base,
  output logic                           out_valid,
  output logic [ADDR_W-1:0]              out_addr,
  output crd_t                           out_crd
);

  logic  prod_valid;
  prod_t prod;
  crd_t  prod_crd;
  prod_t prod_next;

  always_comb begin
    for (int i = 0; i < NUM_DIMS; i++) begin
      prod_next[i] = ADDR_W'({{ADDR_W{1'b0}}, in_crd[i]} * {{EXT_W{1'b0}}, stride[i]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else if (en) begin
      prod_valid <= in_valid;
      out_valid  <= prod_valid;
    end
    if (en) begin
      prod     <= prod_next;
      prod_crd <= in_crd;
      out_addr <= base + prod[0] + prod[1] + prod[2];
      out_crd  <= prod_crd;
    end
  end

endmodule

### hw/rtl/strided_element_address.sv
// Top level of the strided element address generator: registers, divider chain, address sum.
// Pipeline: three 48-stage dividers, then a product stage and a sum stage that is
// the output register.
// Throughput: one item per cycle; the whole pipeline holds while the output waits.
// Reset: synchronous; clears all valid bits and sets the registers to one dimension,
// extents and strides of one, base offset of zero.
module strided_element_address
  import sea_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [ORD_W-1:0]      element_ordinal,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [ADDR_W-1:0]     element_address,
  output logic [EXT_W-1:0]      coord_0,
  output logic [EXT_W-1:0]      coord_1,
  output logic [EXT_W-1:0]      coord_2,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [DIM_W-1:0]                dims_in_use;
  logic [NUM_DIMS-1:0][EXT_W-1:0]  extent;
  logic [NUM_DIMS-1:0][ADDR_W-1:0] stride;
  logic [ADDR_W-1:0]               base_offset;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dims_in_use <= DIM_W'(1);
      extent      <= {NUM_DIMS{EXT_W'(1)}};
      stride      <= {NUM_DIMS{ADDR_W'(1)}};
      base_offset <= '0;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_DIMS:    dims_in_use <= cfg_data[DIM_W-1:0];
        REG_EXT0:    extent[0]   <= cfg_data[EXT_W-1:0];
        REG_EXT1:    extent[1]   <= cfg_data[EXT_W-1:0];
        REG_EXT2:    extent[2]   <= cfg_data[EXT_W-1:0];
        REG_STRIDE0: stride[0]   <= cfg_data[ADDR_W-1:0];
        REG_STRIDE1: stride[1]   <= cfg_data[ADDR_W-1:0];
        REG_STRIDE2: stride[2]   <= cfg_data[ADDR_W-1:0];
        REG_BASE:    base_offset <= cfg_data[ADDR_W-1:0];
        default:     ;
      endcase
    end
  end

  logic             en;
  logic [DIM_W-1:0] n_eff;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;
  assign n_eff    = (dims_in_use == '0) ? DIM_W'(1) : dims_in_use;

  logic             stg_valid [0:NUM_DIMS];
  logic [ORD_W-1:0] stg_dvd   [0:NUM_DIMS];
  crd_t             stg_crd   [0:NUM_DIMS];

  assign stg_valid[0] = in_valid;
  assign stg_dvd[0]   = element_ordinal;
  assign stg_crd[0]   = '0;

  // Divider k resolves dimension n_eff-1-k, the fastest one first.
  for (genvar k = 0; k < NUM_DIMS; k++) begin : g_dim
    logic             active;
    logic [DIM_W-1:0] dim;
    logic [EXT_W-1:0] divisor;
    logic             dv_valid;
    logic [ORD_W-1:0] dv_quo;
    logic [EXT_W-1:0] dv_rem;
    crd_t             dv_crd;

    always_comb begin
      active  = DIM_W'(k) < n_eff;
      dim     = n_eff - DIM_W'(1) - DIM_W'(k);
      divisor = (active && extent[dim] != '0) ? extent[dim] : EXT_W'(1);
    end

    sea_div u_div (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (stg_valid[k]),
      .in_dvd    (stg_dvd[k]),
      .divisor   (divisor),
      .in_crd    (stg_crd[k]),
      .out_valid (dv_valid),
      .out_quo   (dv_quo),
      .out_rem   (dv_rem),
      .out_crd   (dv_crd)
    );

    always_comb begin
      stg_crd[k+1] = dv_crd;
      if (active) begin
        stg_crd[k+1][dim] = dv_rem;
      end
    end

    assign stg_valid[k+1] = dv_valid;
    assign stg_dvd[k+1]   = dv_quo;
  end

  crd_t out_crd;

  sea_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (stg_valid[NUM_DIMS]),
    .in_crd    (stg_crd[NUM_DIMS]),
    .stride    (stride),
    .base      (base_offset),
    .out_valid (out_valid),
    .out_addr  (element_address),
    .out_crd   (out_crd)
  );

  assign coord_0 = out_crd[0];
  assign coord_1 = out_crd[1];
  assign coord_2 = out_crd[2];

  a_stall_from_output: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("pipeline stalled without a waiting result");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_crd)))
    else $error("waiting result changed while stalled");

endmodule

### dv/tb.sv
// Self-checking testbench for the strided element address generator.
`timescale 1ns / 100ps

module tb
  import sea_pkg::*;
();

  localparam int LATENCY = 146;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [EXT_W-1:0]  c0;
    logic [EXT_W-1:0]  c1;
    logic [EXT_W-1:0]  c2;
  } addr_result_t;

  typedef struct {
    logic [ORD_W-1:0] ordinal;
    bit               known;
    addr_result_t     result;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [ORD_W-1:0]      element_ordinal = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [ADDR_W-1:0]     element_address;
  logic [EXT_W-1:0]      coord_0;
  logic [EXT_W-1:0]      coord_1;
  logic [EXT_W-1:0]      coord_2;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic [1:0]        view_dims;
  logic [EXT_W-1:0]  view_extent [NUM_DIMS];
  logic [ADDR_W-1:0] view_stride [NUM_DIMS];
  logic [ADDR_W-1:0] view_base;

  addr_result_t pending_addrs[$];
  int           error_count = 0;
  longint       cycle_count = 0;
  bit           hold_output = 1'b0;

  strided_element_address DUT (.*);

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("Mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
    error_count++;
  endtask

  function automatic addr_result_t locate_element(input logic [ORD_W-1:0] ordinal);
    addr_result_t     r;
    logic [ORD_W-1:0] rest;
    logic [EXT_W-1:0] crd [NUM_DIMS];
    logic [ADDR_W-1:0] sum;
    int               n;
    n = view_dims == 0 ? 1 : int'(view_dims);
    rest = ordinal;
    for (int d = 0; d < NUM_DIMS; d++) crd[d] = '0;
    for (int d = n - 1; d >= 0; d--) begin
      logic [ORD_W-1:0] e;
      e = view_extent[d] == 0 ? ORD_W'(1) : ORD_W'(view_extent[d]);
      crd[d] = EXT_W'(rest % e);
      rest = rest / e;
    end
    sum = view_base;
    for (int d = 0; d < n; d++) sum = sum + ADDR_W'(crd[d]) * view_stride[d];
    r.addr = sum;
    r.c0 = crd[0];
    r.c1 = crd[1];
    r.c2 = crd[2];
    return r;
  endfunction

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_DIMS:    view_dims = value[1:0];
      REG_EXT0:    view_extent[0] = value[EXT_W-1:0];
      REG_EXT1:    view_extent[1] = value[EXT_W-1:0];
      REG_EXT2:    view_extent[2] = value[EXT_W-1:0];
      REG_STRIDE0: view_stride[0] = value;
      REG_STRIDE1: view_stride[1] = value;
      REG_STRIDE2: view_stride[2] = value;
      REG_BASE:    view_base = value;
      default: ;
    endcase
  endtask

  task automatic set_view(input logic [1:0] dims, input logic [EXT_W-1:0] e0,
                          input logic [EXT_W-1:0] e1, input logic [EXT_W-1:0] e2,
                          input logic [31:0] s0, input logic [31:0] s1,
                          input logic [31:0] s2, input logic [31:0] base);
    write_reg(REG_DIMS, 32'(dims));
    write_reg(REG_EXT0, 32'(e0));
    write_reg(REG_EXT1, 32'(e1));
    write_reg(REG_EXT2, 32'(e2));
    write_reg(REG_STRIDE0, s0);
    write_reg(REG_STRIDE1, s1);
    write_reg(REG_STRIDE2, s2);
    write_reg(REG_BASE, base);
    cfg_valid <= 1'b0;
  endtask

  task automatic idle_gap();
    int n;
    n = $urandom_range(0, 99) < 60 ? 0 : ($urandom_range(0, 9) == 0 ?
        $urandom_range(10, 40) : $urandom_range(1, 3));
    if (n != 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_ordinal(input logic [ORD_W-1:0] ordinal, input bit known,
                              input addr_result_t want);
    in_valid <= 1'b1;
    element_ordinal <= ordinal;
    do @(posedge clk); while (!in_ready);
    pending_addrs.push_back(known ? want : locate_element(ordinal));
  endtask

  task automatic drain();
    while (pending_addrs.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  function automatic logic [ORD_W-1:0] random_ordinal(input int mode);
    logic [ORD_W-1:0] span;
    span = ORD_W'(view_extent[0] == 0 ? 1 : view_extent[0]);
    if (view_dims != 1 && view_dims != 0) span = span * (view_extent[1] == 0 ? 1 : view_extent[1]);
    if (view_dims == 3) span = span * (view_extent[2] == 0 ? 1 : view_extent[2]);
    case (mode)
      0: return ORD_W'({$urandom, $urandom} % (span + 1));
      1: return ORD_W'({$urandom, $urandom});
      default: return ORD_W'({$urandom, $urandom}) | (ORD_W'(1) << $urandom_range(0, ORD_W - 1));
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_addrs.size() == 0) begin
        report("unexpected item", element_address, 0);
      end else begin
        addr_result_t want;
        want = pending_addrs.pop_front();
        if (element_address !== want.addr) report("element_address", element_address, want.addr);
        if (coord_0 !== want.c0) report("coord_0", coord_0, want.c0);
        if (coord_1 !== want.c1) report("coord_1", coord_1, want.c1);
        if (coord_2 !== want.c2) report("coord_2", coord_2, want.c2);
      end
    end
  end

  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (hold_output) begin
        out_ready <= 1'b0;
        n = 0;
        while (n < 400) begin
          @(posedge clk);
          n++;
        end
        hold_output = 1'b0;
      end else if ($urandom_range(0, 99) < 25) begin
        out_ready <= 1'b0;
        n = $urandom_range(0, 9) == 0 ? $urandom_range(10, 60) : $urandom_range(1, 3);
        repeat (n) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  stim_row_t directed_rows [$];

  initial begin
    stim_row_t row;
    view_dims = 2'd1;
    for (int d = 0; d < NUM_DIMS; d++) begin
      view_extent[d] = 1;
      view_stride[d] = 1;
    end
    view_base = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed_rows = '{
      '{ORD_W'(0), 1'b1, '{32'd0, 16'd0, 16'd0, 16'd0}},
      '{{ORD_W{1'b1}}, 1'b1, '{32'd0, 16'd0, 16'd0, 16'd0}},
      '{ORD_W'(12345), 1'b1, '{32'd0, 16'd0, 16'd0, 16'd0}}
    };
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_ordinal(row.ordinal, row.known, row.result);
    end
    in_valid <= 1'b0;
    drain();

    set_view(2'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
             32'hFFFFFFFF);
    directed_rows = '{
      '{ORD_W'(0), 1'b1, '{32'hFFFFFFFF, 16'd0, 16'd0, 16'd0}},
      '{ORD_W'(65534), 1'b0, '0},
      '{ORD_W'(65535), 1'b0, '0},
      '{{ORD_W{1'b1}}, 1'b0, '0},
      '{48'hFFFE_FFFE_FFFE, 1'b0, '0},
      '{48'hAAAA_AAAA_AAAA, 1'b0, '0},
      '{48'h5555_5555_5555, 1'b0, '0}
    };
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_ordinal(row.ordinal, row.known, row.result);
    end
    in_valid <= 1'b0;
    drain();

    set_view(2'd0, 16'd0, 16'd7, 16'd0, 32'd5, 32'd0, 32'd3, 32'h8000_0000);
    directed_rows = '{
      '{ORD_W'(99), 1'b0, '0},
      '{{ORD_W{1'b1}}, 1'b0, '0}
    };
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_ordinal(row.ordinal, row.known, row.result);
    end
    in_valid <= 1'b0;
    drain();

    set_view(2'd2, 16'd3, 16'd0, 16'd9, 32'd100, 32'd7, 32'd1, 32'd10);
    directed_rows = '{
      '{ORD_W'(0), 1'b1, '{32'd10, 16'd0, 16'd0, 16'd0}},
      '{ORD_W'(2), 1'b1, '{32'd210, 16'd2, 16'd0, 16'd0}},
      '{ORD_W'(3), 1'b1, '{32'd10, 16'd0, 16'd0, 16'd0}},
      '{ORD_W'(5), 1'b0, '0}
    };
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_ordinal(row.ordinal, row.known, row.result);
    end
    in_valid <= 1'b0;
    drain();

    for (int phase = 0; phase < 14; phase++) begin
      logic [EXT_W-1:0] ex [NUM_DIMS];
      for (int d = 0; d < NUM_DIMS; d++) begin
        case ($urandom_range(0, 5))
          0: ex[d] = 16'hFFFF;
          1: ex[d] = 16'd1;
          2: ex[d] = 16'd0;
          default: ex[d] = EXT_W'($urandom_range(2, 300));
        endcase
      end
      set_view(2'($urandom_range(0, 3)), ex[0], ex[1], ex[2],
               $urandom_range(0, 3) == 0 ? 32'hFFFFFFFF : $urandom,
               $urandom_range(0, 3) == 0 ? 32'd0 : $urandom,
               $urandom_range(0, 3) == 0 ? 32'd1 : $urandom, $urandom);
      if (phase == 3) hold_output = 1'b1;
      repeat (100) begin
        idle_gap();
        send_ordinal(random_ordinal($urandom_range(0, 9) < 7 ? 0 : $urandom_range(1, 2)),
                     1'b0, '0);
      end
      in_valid <= 1'b0;
      drain();
    end

    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
